>>> design/hsvh_pkg.sv
// Shared types, constants and helpers for the hsv color histogram.
// Used by hsvh_bin_map, hsvh_count_table and hsv_color_histogram.

package hsvh_pkg;

    // pixel component and counter widths
    localparam int PIX_W   = 12;
    localparam int COUNT_W = 24;
    localparam int MODE_W  = 2;
    localparam int QIDX_W  = 5;   // index within one axis, up to 32 bins
    localparam int QBIN_W  = 6;   // bin count of one axis, up to 32

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // default bin counts per axis
    localparam int HUE_BINS_DEF = 10;
    localparam int SAT_BINS_DEF = 10;
    localparam int VAL_BINS_DEF = 10;

    // operation codes on the mode field
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_THR = 2'd1;

    // threshold reset values
    localparam logic [PIX_W-1:0] SAT_THR_RST = 12'd410;
    localparam logic [PIX_W-1:0] VAL_THR_RST = 12'd819;

    // decoded operation travelling with an item
    typedef struct packed {
        logic acc;        // increment the bin
        logic rd;         // read the bin
        logic clr;        // clear the whole table
        logic colorless;  // bin is one of the value-only bins
        logic in_range;   // bin index addresses a real bin
    } hsvh_op_t;

    // floor(x * n_bins / 4096), clamped to n_bins - 1
    function automatic logic [QIDX_W-1:0] quantize(input logic [PIX_W-1:0] x,
                                                   input logic [QBIN_W-1:0] n_bins);
        logic [PIX_W+QBIN_W-1:0] prod;
        logic [QBIN_W-1:0]       q;
        logic [QBIN_W-1:0]       top;
        prod = (PIX_W+QBIN_W)'(x) * (PIX_W+QBIN_W)'(n_bins);
        q    = prod[PIX_W+QBIN_W-1:PIX_W];
        top  = n_bins - QBIN_W'(1);
        if (q > top) begin
            q = top;
        end
        return q[QIDX_W-1:0];
    endfunction

endpackage

>>> design/hsvh_bin_map.sv
// Maps one incoming beat to a bin index and a decoded operation.
// Depends on hsvh_pkg for widths, mode codes and the quantizer.

module hsvh_bin_map #(
    parameter int HUE_BINS = hsvh_pkg::HUE_BINS_DEF,
    parameter int SAT_BINS = hsvh_pkg::SAT_BINS_DEF,
    parameter int VAL_BINS = hsvh_pkg::VAL_BINS_DEF,
    parameter int BIN_W    = 7
) (
    input  logic [hsvh_pkg::MODE_W-1:0] mode,
    input  logic [hsvh_pkg::PIX_W-1:0]  hue,
    input  logic [hsvh_pkg::PIX_W-1:0]  sat,
    input  logic [hsvh_pkg::PIX_W-1:0]  val,
    input  logic [BIN_W-1:0]            read_index,
    input  logic [hsvh_pkg::PIX_W-1:0]  sat_thr,
    input  logic [hsvh_pkg::PIX_W-1:0]  val_thr,
    output hsvh_pkg::hsvh_op_t          op,
    output logic [BIN_W-1:0]            bin
);

    localparam int COLORFUL_BINS = HUE_BINS * SAT_BINS;
    localparam int NUM_BINS      = COLORFUL_BINS + VAL_BINS;

    logic [hsvh_pkg::QIDX_W-1:0] qh;
    logic [hsvh_pkg::QIDX_W-1:0] qs;
    logic [hsvh_pkg::QIDX_W-1:0] qv;
    logic                        pix_colorless;
    logic [BIN_W-1:0]            pix_bin;
    logic                        rd_in_range;

    // per-axis quantization
    assign qh = hsvh_pkg::quantize(hue, hsvh_pkg::QBIN_W'(HUE_BINS));
    assign qs = hsvh_pkg::quantize(sat, hsvh_pkg::QBIN_W'(SAT_BINS));
    assign qv = hsvh_pkg::quantize(val, hsvh_pkg::QBIN_W'(VAL_BINS));

    // colorless when either component falls under its threshold
    assign pix_colorless = (sat < sat_thr) || (val < val_thr);

    assign pix_bin = pix_colorless
        ? (BIN_W'(COLORFUL_BINS) + BIN_W'(qv))
        : (BIN_W'(qs) * BIN_W'(HUE_BINS) + BIN_W'(qh));

    assign rd_in_range = (read_index < BIN_W'(NUM_BINS));

    // operation decode
    always_comb begin
        op  = '0;
        bin = '0;
        case (mode)
            hsvh_pkg::MODE_ACCUM: begin
                op.acc       = 1'b1;
                op.colorless = pix_colorless;
                op.in_range  = 1'b1;
                bin          = pix_bin;
            end
            hsvh_pkg::MODE_READ: begin
                op.rd        = 1'b1;
                op.in_range  = rd_in_range;
                op.colorless = rd_in_range && (read_index >= BIN_W'(COLORFUL_BINS));
                bin          = read_index;
            end
            hsvh_pkg::MODE_CLEAR: begin
                op.clr = 1'b1;
            end
            default: begin
                op  = '0;
                bin = '0;
            end
        endcase
    end

endmodule

>>> design/hsvh_count_table.sv
// Bin counter memory with per-entry valid bits, the update stage and
// write-to-read forwarding. Depends on hsvh_pkg for types and widths.

module hsvh_count_table #(
    parameter int NUM_BINS = 110,
    parameter int BIN_W    = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  hsvh_pkg::hsvh_op_t           in_op,
    input  logic [BIN_W-1:0]             in_bin,
    input  logic                         st_move,
    output logic                         st_valid,
    output hsvh_pkg::hsvh_op_t           st_op,
    output logic [BIN_W-1:0]             st_bin,
    output logic [hsvh_pkg::COUNT_W-1:0] res_count,
    output logic                         res_sat
);

    logic [hsvh_pkg::COUNT_W-1:0] count_mem [NUM_BINS];
    logic [NUM_BINS-1:0]          ent_valid_reg;

    logic                         st_valid_reg;
    hsvh_pkg::hsvh_op_t           st_op_reg;
    logic [BIN_W-1:0]             st_bin_reg;
    logic [hsvh_pkg::COUNT_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;
    logic                         fwd_zero_reg;
    logic                         fwd_hit_reg;
    logic [hsvh_pkg::COUNT_W-1:0] fwd_data_reg;

    logic [hsvh_pkg::COUNT_W-1:0] old_count;
    logic [hsvh_pkg::COUNT_W-1:0] new_count;
    logic                         at_max;
    logic                         st_write;
    logic                         in_hit;

    assign st_valid = st_valid_reg;
    assign st_op    = st_op_reg;
    assign st_bin   = st_bin_reg;

    // current count: forwarded from the beat ahead, else memory if written
    always_comb begin
        if (fwd_zero_reg) begin
            old_count = '0;
        end else if (fwd_hit_reg) begin
            old_count = fwd_data_reg;
        end else if (rd_valid_reg) begin
            old_count = rd_data_reg;
        end else begin
            old_count = '0;
        end
    end

    // saturating increment
    assign at_max    = (old_count == hsvh_pkg::COUNT_MAX);
    assign new_count = at_max ? hsvh_pkg::COUNT_MAX : old_count + 1'b1;

    assign st_write = st_move && st_op_reg.acc;
    assign in_hit   = st_write && (st_bin_reg == in_bin);

    // result of the update stage
    always_comb begin
        res_count = '0;
        res_sat   = 1'b0;
        if (st_op_reg.acc) begin
            res_count = new_count;
            res_sat   = at_max;
        end else if (st_op_reg.rd && st_op_reg.in_range) begin
            res_count = old_count;
            res_sat   = at_max;
        end
    end

    // stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (in_fire) begin
            st_valid_reg <= 1'b1;
        end else if (st_move) begin
            st_valid_reg <= 1'b0;
        end
    end

    // stage payload, read port and forwarding flags
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            st_op_reg    <= in_op;
            st_bin_reg   <= in_bin;
            rd_data_reg  <= count_mem[in_bin];
            rd_valid_reg <= in_op.in_range && ent_valid_reg[in_bin];
            fwd_zero_reg <= st_move && st_op_reg.clr;
            fwd_hit_reg  <= in_hit;
            fwd_data_reg <= new_count;
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (st_write) begin
            count_mem[st_bin_reg] <= new_count;
        end
    end

    // entry valid bits, cleared by reset and by the clear operation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (st_move && st_op_reg.clr) begin
            ent_valid_reg <= '0;
        end else if (st_write) begin
            ent_valid_reg[st_bin_reg] <= 1'b1;
        end
    end

endmodule

>>> design/hsv_color_histogram.sv
// HSV color histogram: bins pixels into hue-by-saturation and colorless bins.
// Beats pass the update stage, then the result register; one beat per cycle
// unless m_ready stalls, set by the single bin counter read-modify-write.
// Reset: thresholds return to 410 and 819, all bin counts read as zero at once.
// Depends on hsvh_pkg, hsvh_bin_map and hsvh_count_table.

module hsv_color_histogram #(
    parameter int HUE_BINS = hsvh_pkg::HUE_BINS_DEF,
    parameter int SAT_BINS = hsvh_pkg::SAT_BINS_DEF,
    parameter int VAL_BINS = hsvh_pkg::VAL_BINS_DEF,
    localparam int NUM_BINS = HUE_BINS * SAT_BINS + VAL_BINS,
    localparam int BIN_W    = $clog2(NUM_BINS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hsvh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hsvh_pkg::PIX_W-1:0]       cfg_data,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hsvh_pkg::MODE_W-1:0]      s_mode,
    input  logic [hsvh_pkg::PIX_W-1:0]       s_hue,
    input  logic [hsvh_pkg::PIX_W-1:0]       s_sat,
    input  logic [hsvh_pkg::PIX_W-1:0]       s_val,
    input  logic [BIN_W-1:0]                 s_read_index,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [BIN_W-1:0]                 m_bin_index,
    output logic [hsvh_pkg::COUNT_W-1:0]     m_bin_count,
    output logic                             m_colorless,
    output logic                             m_count_saturated
);

    logic [hsvh_pkg::PIX_W-1:0]   sat_thr_reg;
    logic [hsvh_pkg::PIX_W-1:0]   val_thr_reg;

    hsvh_pkg::hsvh_op_t           in_op;
    logic [BIN_W-1:0]             in_bin;
    logic                         in_fire;

    logic                         st_valid;
    hsvh_pkg::hsvh_op_t           st_op;
    logic [BIN_W-1:0]             st_bin;
    logic                         st_move;
    logic [hsvh_pkg::COUNT_W-1:0] res_count;
    logic                         res_sat;

    logic                         m_valid_reg;
    logic [BIN_W-1:0]             m_bin_index_reg;
    logic [hsvh_pkg::COUNT_W-1:0] m_bin_count_reg;
    logic                         m_colorless_reg;
    logic                         m_count_saturated_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_thr_reg <= hsvh_pkg::SAT_THR_RST;
            val_thr_reg <= hsvh_pkg::VAL_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hsvh_pkg::REG_SAT_THR: sat_thr_reg <= cfg_data;
                hsvh_pkg::REG_VAL_THR: val_thr_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // handshake: update stage moves when the result register is free or drains
    assign st_move = st_valid && (!m_valid_reg || m_ready);
    assign s_ready = !st_valid || st_move;
    assign in_fire = s_valid && s_ready;

    // bin selection for the incoming beat
    hsvh_bin_map #(
        .HUE_BINS (HUE_BINS),
        .SAT_BINS (SAT_BINS),
        .VAL_BINS (VAL_BINS),
        .BIN_W    (BIN_W)
    ) u_bin_map (
        .mode       (s_mode),
        .hue        (s_hue),
        .sat        (s_sat),
        .val        (s_val),
        .read_index (s_read_index),
        .sat_thr    (sat_thr_reg),
        .val_thr    (val_thr_reg),
        .op         (in_op),
        .bin        (in_bin)
    );

    // counter table and update stage
    hsvh_count_table #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_count_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_op     (in_op),
        .in_bin    (in_bin),
        .st_move   (st_move),
        .st_valid  (st_valid),
        .st_op     (st_op),
        .st_bin    (st_bin),
        .res_count (res_count),
        .res_sat   (res_sat)
    );

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (st_move) begin
            m_bin_index_reg       <= (st_op.acc || st_op.rd) ? st_bin : '0;
            m_bin_count_reg       <= res_count;
            m_colorless_reg       <= (st_op.acc || st_op.rd) && st_op.colorless;
            m_count_saturated_reg <= res_sat;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_bin_index       = m_bin_index_reg;
    assign m_bin_count       = m_bin_count_reg;
    assign m_colorless       = m_colorless_reg;
    assign m_count_saturated = m_count_saturated_reg;

endmodule

>>> bench/testbench.sv
// Testbench for hsv_color_histogram: directed and random pixel, read, clear beats.
// Predicts every result from its own copy of the bin table and thresholds.
// Depends on hsvh_pkg and the hsv_color_histogram RTL.
`timescale 1ns / 100ps

module testbench;

    import hsvh_pkg::*;

    // histogram geometry, matching the default build
    localparam int HUE_BINS      = 10;
    localparam int SAT_BINS      = 10;
    localparam int VAL_BINS      = 10;
    localparam int COLORFUL_BINS = HUE_BINS * SAT_BINS;
    localparam int NUM_BINS      = COLORFUL_BINS + VAL_BINS;
    localparam int BIN_W         = $clog2(NUM_BINS);
    localparam int IDX_TOP       = (1 << BIN_W) - 1;
    localparam int PIX_TOP       = (1 << PIX_W) - 1;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_FULL  = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_count;
        logic               colorless;
        logic               count_saturated;
    } hist_result_t;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [PIX_W-1:0]      cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode       = '0;
    logic [PIX_W-1:0]      s_hue        = '0;
    logic [PIX_W-1:0]      s_sat        = '0;
    logic [PIX_W-1:0]      s_val        = '0;
    logic [BIN_W-1:0]      s_read_index = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [BIN_W-1:0]      m_bin_index;
    logic [COUNT_W-1:0]    m_bin_count;
    logic                  m_colorless;
    logic                  m_count_saturated;

    // predicted table and thresholds
    logic [COUNT_W-1:0] tally [NUM_BINS];
    logic [PIX_W-1:0]   sat_thr_q = SAT_THR_RST;
    logic [PIX_W-1:0]   val_thr_q = VAL_THR_RST;
    hist_result_t       expected_tallies [$];

    int sender_gap_pct     = 34;
    int receiver_stall_pct = 69;
    int error_count        = 0;
    int beats_sent         = 0;
    int results_seen       = 0;
    int reg_writes         = 0;
    int cycle_count        = 0;

    hsv_color_histogram dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_hue             (s_hue),
        .s_sat             (s_sat),
        .s_val             (s_val),
        .s_read_index      (s_read_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_bin_index       (m_bin_index),
        .m_bin_count       (m_bin_count),
        .m_colorless       (m_colorless),
        .m_count_saturated (m_count_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // index along one axis, clamped to its top bin
    function automatic int unsigned axis_bin(input logic [PIX_W-1:0] x,
                                             input int unsigned n_bins);
        int unsigned q;
        q = (32'(x) * n_bins) >> PIX_W;
        if (q > n_bins - 1) begin
            q = n_bins - 1;
        end
        return q;
    endfunction

    // apply one beat to the predicted table and return its result
    function automatic hist_result_t tally_beat(input logic [MODE_W-1:0] mode,
                                                input logic [PIX_W-1:0] hue,
                                                input logic [PIX_W-1:0] sat,
                                                input logic [PIX_W-1:0] val,
                                                input logic [BIN_W-1:0] ridx);
        hist_result_t r;
        int unsigned  b;
        r = '0;
        case (mode)
            MODE_ACCUM: begin
                if (sat < sat_thr_q || val < val_thr_q) begin
                    b = COLORFUL_BINS + axis_bin(val, VAL_BINS);
                    r.colorless = 1'b1;
                end else begin
                    b = axis_bin(sat, SAT_BINS) * HUE_BINS + axis_bin(hue, HUE_BINS);
                end
                if (tally[b] == COUNT_FULL) begin
                    r.count_saturated = 1'b1;
                end else begin
                    tally[b] = tally[b] + 1'b1;
                end
                r.bin_index = BIN_W'(b);
                r.bin_count = tally[b];
            end
            MODE_READ: begin
                r.bin_index = ridx;
                if (ridx < NUM_BINS) begin
                    r.bin_count       = tally[ridx];
                    r.colorless       = (ridx >= COLORFUL_BINS);
                    r.count_saturated = (tally[ridx] == COUNT_FULL);
                end
            end
            MODE_CLEAR: begin
                foreach (tally[i]) begin
                    tally[i] = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // one beat on the pixel channel; valid stays high after acceptance
    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [PIX_W-1:0] hue,
                             input logic [PIX_W-1:0] sat,
                             input logic [PIX_W-1:0] val,
                             input logic [BIN_W-1:0] ridx);
        if ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_gap_pct) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_hue        <= hue;
        s_sat        <= sat;
        s_val        <= val;
        s_read_index <= ridx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_tallies.push_back(tally_beat(mode, hue, sat, val, ridx));
        beats_sent++;
    endtask

    // drop valid and wait until every result is back
    task automatic settle_stream();
        s_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // threshold write, only with the pipeline empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        settle_stream();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_SAT_THR) begin
            sat_thr_q = data;
        end else if (idx == REG_VAL_THR) begin
            val_thr_q = data;
        end
        reg_writes++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            error_count++;
        end
    endtask

    // result checker and random receiver stalls
    always @(posedge aclk) begin : result_check
        hist_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_tallies.size() == 0) begin
                $error("result beat with nothing expected, bin_index %0d", m_bin_index);
                error_count++;
            end else begin
                want = expected_tallies.pop_front();
                compare_field("bin_index", 32'(want.bin_index), 32'(m_bin_index));
                compare_field("bin_count", 32'(want.bin_count), 32'(m_bin_count));
                compare_field("colorless", 32'(want.colorless), 32'(m_colorless));
                compare_field("count_saturated", 32'(want.count_saturated),
                              32'(m_count_saturated));
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // run-length guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // table reads as zero right after reset
    task automatic test_reset_state();
        send_beat(MODE_READ, '0, '0, '0, '0);
        send_beat(MODE_READ, '1, '1, '1, BIN_W'(NUM_BINS - 1));
    endtask

    // pixels at the field extremes and on both sides of each threshold
    task automatic test_pixel_extremes();
        send_beat(MODE_ACCUM, '0, '0, '0, '0);
        send_beat(MODE_ACCUM, '1, '1, '1, '1);
        send_beat(MODE_ACCUM, '0, '1, '1, '0);
        send_beat(MODE_ACCUM, '1, 12'd410, 12'd819, '1);
        send_beat(MODE_ACCUM, '1, 12'd409, '1, '0);
        send_beat(MODE_ACCUM, '0, '1, 12'd818, '1);
        send_beat(MODE_ACCUM, '1, '1, '1, '0);
    endtask

    // reads in and out of range, and the unused mode
    task automatic test_read_back();
        send_beat(MODE_READ, '0, '0, '0, BIN_W'(COLORFUL_BINS - 1));
        send_beat(MODE_READ, '0, '0, '0, BIN_W'(COLORFUL_BINS));
        send_beat(MODE_READ, '1, '1, '1, BIN_W'(NUM_BINS));
        send_beat(MODE_READ, '0, '0, '0, BIN_W'(IDX_TOP));
        send_beat(MODE_UNUSED, '1, '1, '1, '1);
    endtask

    task automatic test_clear_table();
        send_beat(MODE_CLEAR, '1, '1, '1, '1);
        send_beat(MODE_READ, '0, '0, '0, BIN_W'(COLORFUL_BINS - 1));
    endtask

    // thresholds at both ends, then back to their reset values
    task automatic test_threshold_extremes();
        write_reg(REG_SAT_THR, '0);
        write_reg(REG_VAL_THR, '0);
        send_beat(MODE_ACCUM, '0, '0, '0, '0);
        write_reg(REG_SAT_THR, '1);
        write_reg(REG_VAL_THR, '1);
        send_beat(MODE_ACCUM, '1, '1, '1, '0);
        send_beat(MODE_ACCUM, '1, 12'd4094, '1, '0);
        send_beat(MODE_ACCUM, '1, '1, 12'd4094, '0);
        write_reg(REG_SAT_THR, SAT_THR_RST);
        write_reg(REG_VAL_THR, VAL_THR_RST);
    endtask

    // mostly pixels, with reads, rare clears and the odd unused mode
    task automatic test_random_stream(input int n_beats);
        int unsigned      pick;
        logic [MODE_W-1:0] mode;
        logic [BIN_W-1:0]  ridx;
        write_reg(REG_SAT_THR, PIX_W'($urandom_range(0, 1200)));
        write_reg(REG_VAL_THR, PIX_W'($urandom_range(0, 1600)));
        for (int i = 0; i < n_beats; i++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                mode = MODE_ACCUM;
            end else if (pick < 92) begin
                mode = MODE_READ;
            end else if (pick < 95) begin
                mode = MODE_CLEAR;
            end else begin
                mode = MODE_UNUSED;
            end
            if ($urandom_range(99) < 80) begin
                ridx = BIN_W'($urandom_range(0, NUM_BINS - 1));
            end else begin
                ridx = BIN_W'($urandom_range(NUM_BINS, IDX_TOP));
            end
            send_beat(mode, PIX_W'($urandom_range(0, PIX_TOP)),
                      PIX_W'($urandom_range(0, PIX_TOP)),
                      PIX_W'($urandom_range(0, PIX_TOP)), ridx);
        end
    endtask

    initial begin
        foreach (tally[i]) begin
            tally[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_pixel_extremes();
        test_read_back();
        test_clear_table();
        test_threshold_extremes();
        test_random_stream(180);

        sender_gap_pct     = 69;
        receiver_stall_pct = 34;
        test_random_stream(180);

        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        test_random_stream(190);

        settle_stream();
        $display("covered %0d beats, %0d results checked, %0d threshold writes",
                 beats_sent, results_seen, reg_writes);
        $display("thresholds at both ends, out-of-range reads, clears, unused mode");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
